>>> rtl/adcfp_pkg.sv
// Shared types, constants and byte-decode helpers for the drive command frame parser.
package adcfp_pkg;

  // Statistics counter width; result ports carry the low 32 bits
  localparam int COUNT_WIDTH = 32;
  localparam int OUT_COUNT_W = 32;

  // Frame layout
  localparam int FRAME_LEN  = 30;
  localparam int POS_W      = $clog2(FRAME_LEN);
  localparam int MAG_W      = 14;
  localparam int SPEED_W    = 11;
  localparam logic [MAG_W-1:0] MAG_LIMIT = 14'd1000;
  localparam logic [3:0] CMD_MAX_DEC = 4'h9;
  localparam logic [3:0] CMD_ALL_ON  = 4'hf;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] POS_ID0     = 5'd1;
  localparam logic [POS_W-1:0] POS_ID1     = 5'd2;
  localparam logic [POS_W-1:0] POS_COMMA0  = 5'd3;
  localparam logic [POS_W-1:0] POS_CMD0    = 5'd4;
  localparam logic [POS_W-1:0] POS_CMD3    = 5'd7;
  localparam logic [POS_W-1:0] POS_COMMA1  = 5'd8;
  localparam logic [POS_W-1:0] POS_LSIGN   = 5'd9;
  localparam logic [POS_W-1:0] POS_LDIG0   = 5'd10;
  localparam logic [POS_W-1:0] POS_LDIG3   = 5'd13;
  localparam logic [POS_W-1:0] POS_COMMA2  = 5'd14;
  localparam logic [POS_W-1:0] POS_RSIGN   = 5'd15;
  localparam logic [POS_W-1:0] POS_RDIG0   = 5'd16;
  localparam logic [POS_W-1:0] POS_RDIG3   = 5'd19;
  localparam logic [POS_W-1:0] POS_COMMA3  = 5'd20;
  localparam logic [POS_W-1:0] POS_SEQ0    = 5'd21;
  localparam logic [POS_W-1:0] POS_SEQ3    = 5'd24;
  localparam logic [POS_W-1:0] POS_COMMA4  = 5'd25;
  localparam logic [POS_W-1:0] POS_HEX_HI  = 5'd26;
  localparam logic [POS_W-1:0] POS_HEX_LO  = 5'd27;
  localparam logic [POS_W-1:0] POS_CR      = 5'd28;
  localparam logic [POS_W-1:0] POS_LAST    = 5'(FRAME_LEN - 1);

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_VALID     = 3'd0,
    STATUS_CHECKSUM  = 3'd1,
    STATUS_MALFORMED = 3'd2,
    STATUS_RANGE     = 3'd3,
    STATUS_FAULT     = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             start;   // '$' opens a new frame
    logic             load;    // take the word at pos into the frame checks
    logic             finish;  // word at pos is the last one: judge the frame
    logic             fault;   // link fault event
    logic [POS_W-1:0] pos;
  } cmd_t;

  function automatic logic is_dec(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_dec(b) || ((b >= CH_UPPER_A) && (b <= CH_UPPER_F));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = is_dec(b) ? (b - CH_ZERO) : (b - HEX_ALPHA_OFS);
    return v[3:0];
  endfunction

  // Accumulate one decimal digit: m * 10 + d
  function automatic logic [MAG_W-1:0] dec_acc(input logic [MAG_W-1:0] m,
                                               input logic [7:0] b);
    logic [MAG_W+2:0] s;
    logic [7:0] d;
    d = b - CH_ZERO;
    s = {m, 3'b000} + {2'b00, m, 1'b0} + (MAG_W+3)'(d[3:0]);
    return s[MAG_W-1:0];
  endfunction

endpackage

>>> rtl/adcfp_ctrl.sv
// Frame controller: tracks frame position, issues datapath commands, owns both handshakes.
module adcfp_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_rx_byte,
  input  logic                     in_link_fault,
  output logic                     out_valid,
  input  logic                     out_ready,
  output adcfp_pkg::cmd_t          cmd
);

  typedef enum logic [1:0] {
    ST_HUNT  = 2'b01,
    ST_FRAME = 2'b10
  } state_t;

  state_t                      state_r, state_nxt;
  logic [adcfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        is_start, would_emit, accept, emit;

  assign is_start = (in_rx_byte == adcfp_pkg::CH_DOLLAR);

  // Flag words that would produce a result this cycle
  assign would_emit = in_link_fault ||
                      ((state_r == ST_FRAME) && (pos_r == adcfp_pkg::POS_LAST) && !is_start);

  // Stall only a word that needs the output register while it is still held
  assign in_ready = !out_valid_r || out_ready || !would_emit;
  assign accept   = in_valid && in_ready;
  assign emit     = accept && would_emit;

  // Decode the accepted word into commands and the next position
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cmd        = '0;
    cmd.pos    = pos_r;
    if (accept) begin
      priority if (in_link_fault) begin
        cmd.fault = 1'b1;
        state_nxt = ST_HUNT;
        pos_nxt   = '0;
      end else if (is_start) begin
        cmd.start = 1'b1;
        state_nxt = ST_FRAME;
        pos_nxt   = adcfp_pkg::POS_ID0;
      end else if (state_r == ST_FRAME) begin
        cmd.load = 1'b1;
        if (pos_r == adcfp_pkg::POS_LAST) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_HUNT;
          pos_nxt    = '0;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end else begin
        // drop words outside a frame
        state_nxt = ST_HUNT;
      end
    end
  end

  // Hold a result until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/adcfp_datapath.sv
// Frame datapath: per-word field checks, checksum, field values, result and statistics registers.
module adcfp_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  adcfp_pkg::cmd_t                      cmd,
  input  logic [7:0]                           rx_byte,
  output logic [2:0]                           status,
  output logic [3:0]                           drive_command,
  output logic signed [adcfp_pkg::SPEED_W-1:0] left_speed,
  output logic signed [adcfp_pkg::SPEED_W-1:0] right_speed,
  output logic [adcfp_pkg::MAG_W-1:0]          sequence_number,
  output logic [adcfp_pkg::OUT_COUNT_W-1:0]    valid_count,
  output logic [adcfp_pkg::OUT_COUNT_W-1:0]    checksum_error_count,
  output logic [adcfp_pkg::OUT_COUNT_W-1:0]    malformed_count,
  output logic [adcfp_pkg::OUT_COUNT_W-1:0]    fault_count
);

  localparam int CW = adcfp_pkg::COUNT_WIDTH;
  localparam int MW = adcfp_pkg::MAG_W;
  localparam int SW = adcfp_pkg::SPEED_W;

  // Per-frame check state
  logic          hdr_bad_r, hdr_bad_nxt;
  logic          hex_bad_r, hex_bad_nxt;
  logic          cmd_bad_r, cmd_bad_nxt;
  logic          seq_bad_r, seq_bad_nxt;
  logic          lfmt_bad_r, lfmt_bad_nxt;
  logic          rfmt_bad_r, rfmt_bad_nxt;
  logic          lneg_r, lneg_nxt;
  logic          rneg_r, rneg_nxt;
  logic [7:0]    xsum_r, xsum_nxt;
  logic [7:0]    hh_r, hh_nxt;
  logic [3:0]    dcmd_r, dcmd_nxt;
  logic [MW-1:0] lmag_r, lmag_nxt;
  logic [MW-1:0] rmag_r, rmag_nxt;
  logic [MW-1:0] seq_r, seq_nxt;

  // Result and statistics
  adcfp_pkg::status_t status_r, status_nxt;
  logic [3:0]    res_cmd_r, res_cmd_nxt;
  logic [SW-1:0] res_left_r, res_left_nxt;
  logic [SW-1:0] res_right_r, res_right_nxt;
  logic [MW-1:0] res_seq_r, res_seq_nxt;
  logic [CW-1:0] valid_total_r, valid_total_nxt;
  logic [CW-1:0] cksum_total_r, cksum_total_nxt;
  logic [CW-1:0] malf_total_r, malf_total_nxt;
  logic [CW-1:0] fault_total_r, fault_total_nxt;

  logic [4:0]          p;
  logic                is_comma_pos, in_cmd, in_ldig, in_rdig, in_seq, in_xsum;
  adcfp_pkg::status_t  verdict;
  logic [SW-1:0]       lmag_s, rmag_s;

  assign p = cmd.pos;

  assign is_comma_pos = (p == adcfp_pkg::POS_COMMA0) || (p == adcfp_pkg::POS_COMMA1) ||
                        (p == adcfp_pkg::POS_COMMA2) || (p == adcfp_pkg::POS_COMMA3) ||
                        (p == adcfp_pkg::POS_COMMA4);
  assign in_cmd  = (p >= adcfp_pkg::POS_CMD0)  && (p <= adcfp_pkg::POS_CMD3);
  assign in_ldig = (p >= adcfp_pkg::POS_LDIG0) && (p <= adcfp_pkg::POS_LDIG3);
  assign in_rdig = (p >= adcfp_pkg::POS_RDIG0) && (p <= adcfp_pkg::POS_RDIG3);
  assign in_seq  = (p >= adcfp_pkg::POS_SEQ0)  && (p <= adcfp_pkg::POS_SEQ3);
  assign in_xsum = (p >= adcfp_pkg::POS_ID0)   && (p <= adcfp_pkg::POS_SEQ3);

  // Fold each word into the frame checks
  always_comb begin
    hdr_bad_nxt  = hdr_bad_r;
    hex_bad_nxt  = hex_bad_r;
    cmd_bad_nxt  = cmd_bad_r;
    seq_bad_nxt  = seq_bad_r;
    lfmt_bad_nxt = lfmt_bad_r;
    rfmt_bad_nxt = rfmt_bad_r;
    lneg_nxt     = lneg_r;
    rneg_nxt     = rneg_r;
    xsum_nxt     = xsum_r;
    hh_nxt       = hh_r;
    dcmd_nxt     = dcmd_r;
    lmag_nxt     = lmag_r;
    rmag_nxt     = rmag_r;
    seq_nxt      = seq_r;
    if (cmd.start) begin
      hdr_bad_nxt  = 1'b0;
      hex_bad_nxt  = 1'b0;
      cmd_bad_nxt  = 1'b0;
      seq_bad_nxt  = 1'b0;
      lfmt_bad_nxt = 1'b0;
      rfmt_bad_nxt = 1'b0;
      xsum_nxt     = '0;
      dcmd_nxt     = '0;
      lmag_nxt     = '0;
      rmag_nxt     = '0;
      seq_nxt      = '0;
    end else if (cmd.load) begin
      if (in_xsum) begin
        xsum_nxt = xsum_r ^ rx_byte;
      end
      if (p == adcfp_pkg::POS_ID0 && rx_byte != adcfp_pkg::CH_X) begin
        hdr_bad_nxt = 1'b1;
      end
      if (p == adcfp_pkg::POS_ID1 && rx_byte != adcfp_pkg::CH_C) begin
        hdr_bad_nxt = 1'b1;
      end
      if (is_comma_pos && rx_byte != adcfp_pkg::CH_COMMA) begin
        hdr_bad_nxt = 1'b1;
      end
      if (p == adcfp_pkg::POS_CR && rx_byte != adcfp_pkg::CH_CR) begin
        hdr_bad_nxt = 1'b1;
      end
      if (p == adcfp_pkg::POS_HEX_HI || p == adcfp_pkg::POS_HEX_LO) begin
        if (!adcfp_pkg::is_hex(rx_byte)) begin
          hex_bad_nxt = 1'b1;
        end
        if (p == adcfp_pkg::POS_HEX_HI) begin
          hh_nxt[7:4] = adcfp_pkg::hex_val(rx_byte);
        end else begin
          hh_nxt[3:0] = adcfp_pkg::hex_val(rx_byte);
        end
      end
      if (in_cmd) begin
        if (rx_byte != adcfp_pkg::CH_ZERO && rx_byte != adcfp_pkg::CH_ONE) begin
          cmd_bad_nxt = 1'b1;
        end
        dcmd_nxt = {dcmd_r[2:0], rx_byte[0]};
      end
      if (p == adcfp_pkg::POS_LSIGN) begin
        lneg_nxt = (rx_byte == adcfp_pkg::CH_MINUS);
        if (rx_byte != adcfp_pkg::CH_PLUS && rx_byte != adcfp_pkg::CH_MINUS) begin
          lfmt_bad_nxt = 1'b1;
        end
      end
      if (p == adcfp_pkg::POS_RSIGN) begin
        rneg_nxt = (rx_byte == adcfp_pkg::CH_MINUS);
        if (rx_byte != adcfp_pkg::CH_PLUS && rx_byte != adcfp_pkg::CH_MINUS) begin
          rfmt_bad_nxt = 1'b1;
        end
      end
      if (in_ldig) begin
        lfmt_bad_nxt = lfmt_bad_nxt || !adcfp_pkg::is_dec(rx_byte);
        lmag_nxt     = adcfp_pkg::dec_acc(lmag_r, rx_byte);
      end
      if (in_rdig) begin
        rfmt_bad_nxt = rfmt_bad_nxt || !adcfp_pkg::is_dec(rx_byte);
        rmag_nxt     = adcfp_pkg::dec_acc(rmag_r, rx_byte);
      end
      if (in_seq) begin
        seq_bad_nxt = seq_bad_r || !adcfp_pkg::is_dec(rx_byte);
        seq_nxt     = adcfp_pkg::dec_acc(seq_r, rx_byte);
      end
    end
  end

  // Judge the frame on its last word; the first failing check wins
  always_comb begin
    priority if (hdr_bad_r || rx_byte != adcfp_pkg::CH_LF) begin
      verdict = adcfp_pkg::STATUS_MALFORMED;
    end else if (hex_bad_r) begin
      verdict = adcfp_pkg::STATUS_MALFORMED;
    end else if (hh_r != xsum_r) begin
      verdict = adcfp_pkg::STATUS_CHECKSUM;
    end else if (cmd_bad_r || seq_bad_r || lfmt_bad_r) begin
      verdict = adcfp_pkg::STATUS_MALFORMED;
    end else if (lmag_r > adcfp_pkg::MAG_LIMIT) begin
      verdict = adcfp_pkg::STATUS_RANGE;
    end else if (rfmt_bad_r) begin
      verdict = adcfp_pkg::STATUS_MALFORMED;
    end else if (rmag_r > adcfp_pkg::MAG_LIMIT) begin
      verdict = adcfp_pkg::STATUS_RANGE;
    end else if (dcmd_r > adcfp_pkg::CMD_MAX_DEC && dcmd_r != adcfp_pkg::CMD_ALL_ON) begin
      verdict = adcfp_pkg::STATUS_MALFORMED;
    end else begin
      verdict = adcfp_pkg::STATUS_VALID;
    end
  end

  assign lmag_s = lmag_r[SW-1:0];
  assign rmag_s = rmag_r[SW-1:0];

  // Load the result word and advance the matching counter
  always_comb begin
    status_nxt      = status_r;
    res_cmd_nxt     = res_cmd_r;
    res_left_nxt    = res_left_r;
    res_right_nxt   = res_right_r;
    res_seq_nxt     = res_seq_r;
    valid_total_nxt = valid_total_r;
    cksum_total_nxt = cksum_total_r;
    malf_total_nxt  = malf_total_r;
    fault_total_nxt = fault_total_r;
    if (cmd.fault || cmd.finish) begin
      res_cmd_nxt   = '0;
      res_left_nxt  = '0;
      res_right_nxt = '0;
      res_seq_nxt   = '0;
    end
    if (cmd.fault) begin
      status_nxt      = adcfp_pkg::STATUS_FAULT;
      fault_total_nxt = fault_total_r + CW'(1);
    end else if (cmd.finish) begin
      status_nxt = verdict;
      unique case (verdict)
        adcfp_pkg::STATUS_VALID: begin
          valid_total_nxt = valid_total_r + CW'(1);
          res_cmd_nxt     = dcmd_r;
          res_left_nxt    = lneg_r ? (SW'(0) - lmag_s) : lmag_s;
          res_right_nxt   = rneg_r ? (SW'(0) - rmag_s) : rmag_s;
          res_seq_nxt     = seq_r;
        end
        adcfp_pkg::STATUS_CHECKSUM: begin
          cksum_total_nxt = cksum_total_r + CW'(1);
        end
        default: begin
          malf_total_nxt = malf_total_r + CW'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    hdr_bad_r   <= hdr_bad_nxt;
    hex_bad_r   <= hex_bad_nxt;
    cmd_bad_r   <= cmd_bad_nxt;
    seq_bad_r   <= seq_bad_nxt;
    lfmt_bad_r  <= lfmt_bad_nxt;
    rfmt_bad_r  <= rfmt_bad_nxt;
    lneg_r      <= lneg_nxt;
    rneg_r      <= rneg_nxt;
    xsum_r      <= xsum_nxt;
    hh_r        <= hh_nxt;
    dcmd_r      <= dcmd_nxt;
    lmag_r      <= lmag_nxt;
    rmag_r      <= rmag_nxt;
    seq_r       <= seq_nxt;
    status_r    <= status_nxt;
    res_cmd_r   <= res_cmd_nxt;
    res_left_r  <= res_left_nxt;
    res_right_r <= res_right_nxt;
    res_seq_r   <= res_seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_total_r <= '0;
      cksum_total_r <= '0;
      malf_total_r  <= '0;
      fault_total_r <= '0;
    end else begin
      valid_total_r <= valid_total_nxt;
      cksum_total_r <= cksum_total_nxt;
      malf_total_r  <= malf_total_nxt;
      fault_total_r <= fault_total_nxt;
    end
  end

  assign status               = status_r;
  assign drive_command        = res_cmd_r;
  assign left_speed           = $signed(res_left_r);
  assign right_speed          = $signed(res_right_r);
  assign sequence_number      = res_seq_r;
  assign valid_count          = adcfp_pkg::OUT_COUNT_W'(valid_total_r);
  assign checksum_error_count = adcfp_pkg::OUT_COUNT_W'(cksum_total_r);
  assign malformed_count      = adcfp_pkg::OUT_COUNT_W'(malf_total_r);
  assign fault_count          = adcfp_pkg::OUT_COUNT_W'(fault_total_r);

endmodule

>>> rtl/ascii_drive_command_frame_parser.sv
// Top level of the ASCII drive command frame parser: controller plus datapath.
//
// Input channel (in_valid/in_ready): one word per received UART byte, or a link
// fault event when in_link_fault is set. A '$' opens a 30-byte frame; words
// outside a frame are dropped. Each word is checked as it arrives, so nothing
// is re-read at frame end.
// Output channel (out_valid/out_ready): one word per completed frame and one per
// link fault, carrying status, the parsed fields (zero unless status is valid)
// and the four wrapping statistics counters after that event.
// Throughput: one input word per cycle while in_ready is high. The result word
// is presented the cycle after the closing LF (or the fault event) is accepted.
// Reset (rst_n low, synchronous) closes any open frame, clears the counters and
// empties the output register.
// Stall: the output register holds a result until taken; meanwhile words that
// produce no result are still accepted, and in_ready drops only for a word that
// would produce the next result.
module ascii_drive_command_frame_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_rx_byte,
  input  logic                                 in_link_fault,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           out_status,
  output logic [3:0]                           out_drive_command,
  output logic signed [adcfp_pkg::SPEED_W-1:0] out_left_speed,
  output logic signed [adcfp_pkg::SPEED_W-1:0] out_right_speed,
  output logic [adcfp_pkg::MAG_W-1:0]          out_sequence_number,
  output logic [adcfp_pkg::OUT_COUNT_W-1:0]    out_valid_count,
  output logic [adcfp_pkg::OUT_COUNT_W-1:0]    out_checksum_error_count,
  output logic [adcfp_pkg::OUT_COUNT_W-1:0]    out_malformed_count,
  output logic [adcfp_pkg::OUT_COUNT_W-1:0]    out_fault_count
);

  adcfp_pkg::cmd_t cmd;

  // Frame position and handshakes
  adcfp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .in_link_fault (in_link_fault),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd)
  );

  // Field checks, result and counters
  adcfp_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .rx_byte              (in_rx_byte),
    .status               (out_status),
    .drive_command        (out_drive_command),
    .left_speed           (out_left_speed),
    .right_speed          (out_right_speed),
    .sequence_number      (out_sequence_number),
    .valid_count          (out_valid_count),
    .checksum_error_count (out_checksum_error_count),
    .malformed_count      (out_malformed_count),
    .fault_count          (out_fault_count)
  );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the ASCII drive command frame parser.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import adcfp_pkg::*;

  // One result word as the block should present it
  typedef struct packed {
    status_t              status;
    logic [3:0]           command;
    logic signed [10:0]   left;
    logic signed [10:0]   right;
    logic [13:0]          seq;
    logic [31:0]          valid_cnt;
    logic [31:0]          checksum_cnt;
    logic [31:0]          malformed_cnt;
    logic [31:0]          fault_cnt;
  } drive_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                in_link_fault = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          out_status;
  logic [3:0]          out_drive_command;
  logic signed [10:0]  out_left_speed;
  logic signed [10:0]  out_right_speed;
  logic [13:0]         out_sequence_number;
  logic [31:0]         out_valid_count;
  logic [31:0]         out_checksum_error_count;
  logic [31:0]         out_malformed_count;
  logic [31:0]         out_fault_count;

  // Predictor state: open frame, write position and the four totals
  logic [7:0]             rx_frame [FRAME_LEN];
  int                     rx_pos = 0;
  logic [COUNT_WIDTH-1:0] total_valid = '0;
  logic [COUNT_WIDTH-1:0] total_checksum = '0;
  logic [COUNT_WIDTH-1:0] total_malformed = '0;
  logic [COUNT_WIDTH-1:0] total_fault = '0;

  drive_report_t pending_reports [$];
  logic [7:0]    frame_draft [FRAME_LEN];

  int  words_sent = 0;
  int  mismatch_count = 0;
  int  sink_stall = 0;
  bit  sender_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;

  ascii_drive_command_frame_parser i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_rx_byte               (in_rx_byte),
    .in_link_fault            (in_link_fault),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_status               (out_status),
    .out_drive_command        (out_drive_command),
    .out_left_speed           (out_left_speed),
    .out_right_speed          (out_right_speed),
    .out_sequence_number      (out_sequence_number),
    .out_valid_count          (out_valid_count),
    .out_checksum_error_count (out_checksum_error_count),
    .out_malformed_count      (out_malformed_count),
    .out_fault_count          (out_fault_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit read_decimal(input int first, output int value);
    value = 0;
    for (int k = 0; k < 4; k++) begin
      if (rx_frame[first + k] < CH_ZERO || rx_frame[first + k] > CH_NINE) return 1'b0;
      value = value * 10 + int'(rx_frame[first + k] - CH_ZERO);
    end
    return 1'b1;
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 4'(c - CH_ZERO);
      return 1'b1;
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v = 4'(c - CH_UPPER_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Sign plus four digits; a bad character beats an oversize magnitude
  function automatic status_t speed_field(input int first, output logic signed [10:0] v);
    int mag;
    v = '0;
    if (rx_frame[first] != CH_PLUS && rx_frame[first] != CH_MINUS) return STATUS_MALFORMED;
    if (!read_decimal(first + 1, mag)) return STATUS_MALFORMED;
    if (mag > 1000) return STATUS_RANGE;
    v = (rx_frame[first] == CH_MINUS) ? 11'(-mag) : 11'(mag);
    return STATUS_VALID;
  endfunction

  // Judge a complete frame; the first failing check decides the status
  function automatic status_t judge_frame(output drive_report_t r);
    logic [7:0] sum;
    logic [3:0] hi, lo;
    logic [3:0] command;
    int seq;
    status_t side;
    r = '0;
    sum = 8'h00;
    command = 4'h0;
    if (rx_frame[0] != CH_DOLLAR || rx_frame[POS_ID0] != CH_X || rx_frame[POS_ID1] != CH_C ||
        rx_frame[POS_CR] != CH_CR || rx_frame[POS_LAST] != CH_LF)
      return STATUS_MALFORMED;
    if (rx_frame[POS_COMMA0] != CH_COMMA || rx_frame[POS_COMMA1] != CH_COMMA ||
        rx_frame[POS_COMMA2] != CH_COMMA || rx_frame[POS_COMMA3] != CH_COMMA ||
        rx_frame[POS_COMMA4] != CH_COMMA)
      return STATUS_MALFORMED;
    for (int k = POS_ID0; k <= POS_SEQ3; k++) sum ^= rx_frame[k];
    if (!hex_nibble(rx_frame[POS_HEX_HI], hi) || !hex_nibble(rx_frame[POS_HEX_LO], lo))
      return STATUS_MALFORMED;
    if ({hi, lo} != sum) return STATUS_CHECKSUM;
    for (int k = 0; k < 4; k++) begin
      if (rx_frame[POS_CMD0 + k] != CH_ZERO && rx_frame[POS_CMD0 + k] != CH_ONE)
        return STATUS_MALFORMED;
      command = {command[2:0], rx_frame[POS_CMD0 + k] == CH_ONE};
    end
    if (!read_decimal(POS_SEQ0, seq)) return STATUS_MALFORMED;
    side = speed_field(POS_LSIGN, r.left);
    if (side != STATUS_VALID) return side;
    side = speed_field(POS_RSIGN, r.right);
    if (side != STATUS_VALID) return side;
    if (command > CMD_MAX_DEC && command != CMD_ALL_ON) return STATUS_MALFORMED;
    r.command = command;
    r.seq = 14'(seq);
    return STATUS_VALID;
  endfunction

  // Advance the predictor by one accepted word; queue the result it causes
  function automatic void take_word(input logic [7:0] b, input logic fault);
    drive_report_t r;
    status_t st;
    bit emit;
    r = '0;
    emit = 1'b0;
    st = STATUS_FAULT;
    words_sent++;
    if (fault) begin
      rx_pos = 0;
      total_fault++;
      emit = 1'b1;
    end else if (b == CH_DOLLAR) begin
      rx_frame[0] = b;
      rx_pos = 1;
    end else if (rx_pos == 0 || rx_pos >= FRAME_LEN) begin
      rx_pos = 0;
    end else begin
      rx_frame[rx_pos] = b;
      rx_pos++;
      if (rx_pos == FRAME_LEN) begin
        rx_pos = 0;
        st = judge_frame(r);
        if (st != STATUS_VALID) r = '0;
        case (st)
          STATUS_VALID:    total_valid++;
          STATUS_CHECKSUM: total_checksum++;
          default:         total_malformed++;
        endcase
        emit = 1'b1;
      end
    end
    if (emit) begin
      r.status = st;
      r.valid_cnt = total_valid[31:0];
      r.checksum_cnt = total_checksum[31:0];
      r.malformed_cnt = total_malformed[31:0];
      r.fault_cnt = total_fault[31:0];
      pending_reports.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void show_mismatch(input string what, input drive_report_t got,
                                        input drive_report_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: got st=%0d cmd=%h l=%0d r=%0d seq=%0d cnt=%0d/%0d/%0d/%0d", $realtime,
               what, got.status, got.command, got.left, got.right, got.seq, got.valid_cnt,
               got.checksum_cnt, got.malformed_cnt, got.fault_cnt);
      $display("    expected st=%0d cmd=%h l=%0d r=%0d seq=%0d cnt=%0d/%0d/%0d/%0d",
               want.status, want.command, want.left, want.right, want.seq, want.valid_cnt,
               want.checksum_cnt, want.malformed_cnt, want.fault_cnt);
    end
  endfunction

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    drive_report_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_t'(out_status);
      got.command = out_drive_command;
      got.left = out_left_speed;
      got.right = out_right_speed;
      got.seq = out_sequence_number;
      got.valid_cnt = out_valid_count;
      got.checksum_cnt = out_checksum_error_count;
      got.malformed_cnt = out_malformed_count;
      got.fault_cnt = out_fault_count;
      if (pending_reports.size() == 0) begin
        show_mismatch("unexpected result", got, '0);
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status || got.command !== want.command ||
            got.left !== want.left || got.right !== want.right || got.seq !== want.seq ||
            got.valid_cnt !== want.valid_cnt || got.checksum_cnt !== want.checksum_cnt ||
            got.malformed_cnt !== want.malformed_cnt || got.fault_cnt !== want.fault_cnt)
          show_mismatch("result mismatch", got, want);
      end
      sink_stall = sink_idle_on ? $urandom_range(0, 12) : 0;
    end
  end

  // Hold off the result channel for the drawn number of cycles after each word
  always @(negedge clk) begin
    if (!rst_n || sink_stall > 0) begin
      out_ready <= 1'b0;
      if (sink_stall > 0) sink_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Send one word; entered and left at a falling edge
  task automatic send_word(input logic [7:0] rx_byte, input logic fault);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= rx_byte;
    in_link_fault <= fault;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_word(rx_byte, fault);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_UPPER_A + 8'(v - 4'd10);
  endfunction

  function automatic void put_decimal(input int first, input int value);
    int divisor;
    divisor = 1000;
    for (int k = 0; k < 4; k++) begin
      frame_draft[first + k] = CH_ZERO + 8'((value / divisor) % 10);
      divisor = divisor / 10;
    end
  endfunction

  // Recompute the hex checksum over the draft
  function automatic void seal_draft();
    logic [7:0] sum;
    sum = 8'h00;
    for (int k = POS_ID0; k <= POS_SEQ3; k++) sum ^= frame_draft[k];
    frame_draft[POS_HEX_HI] = hex_char(sum[7:4]);
    frame_draft[POS_HEX_LO] = hex_char(sum[3:0]);
  endfunction

  function automatic void compose_frame(input logic [3:0] command, input bit lneg,
                                        input int lmag, input bit rneg, input int rmag,
                                        input int seq);
    frame_draft[0] = CH_DOLLAR;
    frame_draft[POS_ID0] = CH_X;
    frame_draft[POS_ID1] = CH_C;
    frame_draft[POS_COMMA0] = CH_COMMA;
    frame_draft[POS_COMMA1] = CH_COMMA;
    frame_draft[POS_COMMA2] = CH_COMMA;
    frame_draft[POS_COMMA3] = CH_COMMA;
    frame_draft[POS_COMMA4] = CH_COMMA;
    for (int k = 0; k < 4; k++) frame_draft[POS_CMD0 + k] = command[3 - k] ? CH_ONE : CH_ZERO;
    frame_draft[POS_LSIGN] = lneg ? CH_MINUS : CH_PLUS;
    put_decimal(POS_LDIG0, lmag);
    frame_draft[POS_RSIGN] = rneg ? CH_MINUS : CH_PLUS;
    put_decimal(POS_RDIG0, rmag);
    put_decimal(POS_SEQ0, seq);
    frame_draft[POS_CR] = CH_CR;
    frame_draft[POS_LAST] = CH_LF;
    seal_draft();
  endfunction

  task automatic send_draft(input int count);
    for (int k = 0; k < count; k++) send_word(frame_draft[k], 1'b0);
  endtask

  function automatic int pick_speed();
    case ($urandom_range(0, 5))
      0:       return 1000;
      1:       return $urandom_range(0, 1) ? 0 : 999;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // Well-formed frame with random legal content
  function automatic void random_frame();
    logic [3:0] command;
    command = 4'($urandom_range(0, 10));
    if (command == 4'd10) command = CMD_ALL_ON;
    compose_frame(command, 1'($urandom_range(0, 1)), pick_speed(), 1'($urandom_range(0, 1)),
                  pick_speed(), $urandom_range(0, 9) == 0 ? 9999 : $urandom_range(0, 9999));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_valid_frames();
    compose_frame(4'b1111, 1'b1, 1000, 1'b0, 1000, 9999);
    send_draft(FRAME_LEN);
    compose_frame(4'b0000, 1'b0, 0, 1'b1, 0, 0);
    send_draft(FRAME_LEN);
    compose_frame(4'b1001, 1'b0, 1000, 1'b1, 1000, 1234);
    send_draft(FRAME_LEN);
  endtask

  task automatic test_frame_errors();
    // wrong hex value, then non-hex digits
    compose_frame(4'b0101, 1'b0, 500, 1'b1, 250, 42);
    frame_draft[POS_HEX_LO] = hex_char(4'(frame_draft[POS_HEX_LO] + 8'd1));
    send_draft(FRAME_LEN);
    frame_draft[POS_HEX_HI] = 8'h61;
    send_draft(FRAME_LEN);
    frame_draft[POS_HEX_HI] = 8'h47;
    send_draft(FRAME_LEN);
    // header, comma and terminator faults
    compose_frame(4'b0011, 1'b0, 1, 1'b0, 1, 1);
    frame_draft[POS_ID0] = 8'h59;
    send_draft(FRAME_LEN);
    compose_frame(4'b0011, 1'b0, 1, 1'b0, 1, 1);
    frame_draft[POS_COMMA2] = 8'h3b;
    seal_draft();
    send_draft(FRAME_LEN);
    compose_frame(4'b0011, 1'b0, 1, 1'b0, 1, 1);
    frame_draft[POS_CR] = CH_LF;
    send_draft(FRAME_LEN);
    compose_frame(4'b0011, 1'b0, 1, 1'b0, 1, 1);
    frame_draft[POS_LAST] = CH_CR;
    send_draft(FRAME_LEN);
    // bad command digit, bad sequence digit, bad sign
    compose_frame(4'b0001, 1'b0, 7, 1'b0, 7, 7);
    frame_draft[POS_CMD3] = 8'h32;
    seal_draft();
    send_draft(FRAME_LEN);
    compose_frame(4'b0001, 1'b0, 7, 1'b0, 7, 7);
    frame_draft[POS_SEQ3] = 8'h3a;
    seal_draft();
    send_draft(FRAME_LEN);
    compose_frame(4'b0001, 1'b0, 7, 1'b0, 7, 7);
    frame_draft[POS_LSIGN] = 8'h20;
    seal_draft();
    send_draft(FRAME_LEN);
    // magnitude over the limit on either side
    compose_frame(4'b0010, 1'b1, 1001, 1'b0, 10, 10);
    send_draft(FRAME_LEN);
    compose_frame(4'b0010, 1'b0, 10, 1'b1, 9999, 10);
    send_draft(FRAME_LEN);
    // the left field is judged before the right, whichever way each one fails
    compose_frame(4'b0010, 1'b0, 10, 1'b0, 5000, 10);
    frame_draft[POS_LDIG0] = 8'h2f;
    seal_draft();
    send_draft(FRAME_LEN);
    compose_frame(4'b0010, 1'b0, 1500, 1'b0, 10, 10);
    frame_draft[POS_RSIGN] = CH_COMMA;
    seal_draft();
    send_draft(FRAME_LEN);
    // binary commands outside 0..9 and 15
    compose_frame(4'b1010, 1'b0, 0, 1'b0, 0, 0);
    send_draft(FRAME_LEN);
    compose_frame(4'b1110, 1'b0, 0, 1'b0, 0, 0);
    send_draft(FRAME_LEN);
  endtask

  task automatic test_framing();
    // drop words outside a frame
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(CH_LF, 1'b0);
    // restart on '$' in the middle of a frame
    random_frame();
    send_draft(17);
    random_frame();
    send_draft(FRAME_LEN);
    // trailing words after a complete frame
    send_word(CH_COMMA, 1'b0);
    send_word(8'h80, 1'b0);
    // link fault drops the open frame; the rest of it is ignored
    random_frame();
    send_draft(12);
    send_word(CH_DOLLAR, 1'b1);
    for (int k = 12; k < FRAME_LEN; k++) send_word(frame_draft[k], 1'b0);
    send_word(8'h5a, 1'b1);
    send_word(8'ha5, 1'b1);
  endtask

  // Pause the sender until every result is out, then carry on
  task automatic test_drain_pause();
    random_frame();
    send_draft(FRAME_LEN);
    send_word(8'h00, 1'b1);
    wait_drained();
    random_frame();
    send_draft(FRAME_LEN);
  endtask

  task automatic test_random_traffic();
    int choice;
    int span;
    int rounds;
    rounds = 0;
    while (words_sent < 1500) begin
      // change the idling pattern now and then, with stretches of none
      if (rounds % 12 == 0) begin
        sender_idle_on = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
      end
      rounds++;
      random_frame();
      choice = $urandom_range(0, 99);
      if (choice < 48) begin
        send_draft(FRAME_LEN);
      end else if (choice < 56) begin
        for (int k = 0; k < 4; k++)
          frame_draft[POS_CMD0 + k] = $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
        seal_draft();
        send_draft(FRAME_LEN);
      end else if (choice < 62) begin
        frame_draft[POS_HEX_HI + $urandom_range(0, 1)] = hex_char(4'($urandom_range(0, 15)));
        send_draft(FRAME_LEN);
      end else if (choice < 72) begin
        frame_draft[$urandom_range(1, FRAME_LEN - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) seal_draft();
        send_draft(FRAME_LEN);
      end else if (choice < 78) begin
        put_decimal($urandom_range(0, 1) ? POS_LDIG0 : POS_RDIG0,
                    $urandom_range(0, 2) == 0 ? 1001 : $urandom_range(1001, 9999));
        seal_draft();
        send_draft(FRAME_LEN);
      end else if (choice < 84) begin
        send_draft($urandom_range(1, FRAME_LEN - 1));
      end else if (choice < 89) begin
        span = $urandom_range(1, FRAME_LEN - 1);
        send_draft(span);
        send_word(8'($urandom_range(0, 255)), 1'b1);
        for (int k = span; k < FRAME_LEN; k++) send_word(frame_draft[k], 1'b0);
      end else if (choice < 96) begin
        repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_valid_frames();
    test_frame_errors();
    test_framing();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/adcfp_pkg.sv
rtl/adcfp_ctrl.sv
rtl/adcfp_datapath.sv
rtl/ascii_drive_command_frame_parser.sv
sim/testbench.sv
